// File: design/cus_pkg.sv
// ----------------------------------------------------------------------------
// cus_pkg
// shared constants and controller/datapath interface types for the
// conservative update sketch
// ----------------------------------------------------------------------------
package cus_pkg;

  // default geometry
  localparam int              CUS_ROWS        = 4;
  localparam int              CUS_COLUMNS     = 1024;
  localparam longint unsigned CUS_COUNTER_MAX = 64'd65535;

  // fixed field widths
  localparam int INDEX_W      = 10;
  localparam int INDEX_FIELDS = 4;
  localparam int EST_W        = 16;

  // opcodes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic clear;   // write zero at the clear pointer in every bank
    logic load;    // capture opcode and column addresses
    logic read;    // issue the bank reads
    logic min;     // register the minimum of the read counters
    logic update;  // write back increments, emit query result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;  // clear pointer is at the last column
  } sts_t;

endpackage

// File: design/conservative_update_sketch.sv
// ----------------------------------------------------------------------------
// conservative_update_sketch
// count-min sketch with conservative update over ROWS counter banks
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. After reset the block
// runs a clearing pass that zeroes every counter, with busy high throughout.
// Each item then passes through the states that issue the bank reads, take
// the minimum of the registered read data and write back the incremented
// counters, with busy high, and busy drops in the idle state in which the
// next start is taken, so no new item is taken before the last one has been
// written back. A query raises done for exactly one cycle with the estimate,
// registered in the write-back state; the receiver cannot stall, so it must
// take the result in that cycle. An insert gives no result.
// ----------------------------------------------------------------------------
module conservative_update_sketch #(
  parameter int              ROWS        = cus_pkg::CUS_ROWS,
  parameter int              COLUMNS     = cus_pkg::CUS_COLUMNS,
  parameter longint unsigned COUNTER_MAX = cus_pkg::CUS_COUNTER_MAX
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        opcode,
  input  logic [cus_pkg::INDEX_W-1:0] row0_index,
  input  logic [cus_pkg::INDEX_W-1:0] row1_index,
  input  logic [cus_pkg::INDEX_W-1:0] row2_index,
  input  logic [cus_pkg::INDEX_W-1:0] row3_index,
  output logic [cus_pkg::EST_W-1:0]   estimate,
  output logic                        done
);
  import cus_pkg::*;

  cmd_t               cmd;
  sts_t               sts;
  logic [INDEX_W-1:0] idx [INDEX_FIELDS];

  // rows beyond the fourth reuse the index fields in turn
  assign idx[0] = row0_index;
  assign idx[1] = row1_index;
  assign idx[2] = row2_index;
  assign idx[3] = row3_index;

  // sequencer: clearing pass, then read / min / update per transfer
  cus_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  // banks, minimum and write-back
  cus_dp #(
    .ROWS        (ROWS),
    .COLUMNS     (COLUMNS),
    .COUNTER_MAX (COUNTER_MAX)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .opcode   (opcode),
    .idx      (idx),
    .estimate (estimate),
    .done     (done)
  );

endmodule

// File: design/cus_ctrl.sv
// ----------------------------------------------------------------------------
// cus_ctrl
// sequencer: clearing pass after reset, then read / min / update per item
// ----------------------------------------------------------------------------
module cus_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  output cus_pkg::cmd_t cmd,
  input  cus_pkg::sts_t sts
);
  import cus_pkg::*;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_READ   = 3'd2;
  localparam logic [2:0] ST_MIN    = 3'd3;
  localparam logic [2:0] ST_UPDATE = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        cmd.read   = 1'b1;
        state_next = ST_MIN;
      end
      ST_MIN: begin
        cmd.min    = 1'b1;
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

// File: design/cus_dp.sv
// ----------------------------------------------------------------------------
// cus_dp
// counter banks, column reduction, minimum and conservative write-back
// ----------------------------------------------------------------------------
module cus_dp #(
  parameter int              ROWS        = cus_pkg::CUS_ROWS,
  parameter int              COLUMNS     = cus_pkg::CUS_COLUMNS,
  parameter longint unsigned COUNTER_MAX = cus_pkg::CUS_COUNTER_MAX
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cus_pkg::cmd_t                cmd,
  output cus_pkg::sts_t                sts,
  input  logic                         opcode,
  input  logic [cus_pkg::INDEX_W-1:0]  idx [cus_pkg::INDEX_FIELDS],
  output logic [cus_pkg::EST_W-1:0]    estimate,
  output logic                         done
);
  import cus_pkg::*;

  localparam int COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int CNT_W = $clog2(COUNTER_MAX + 64'd1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(COUNTER_MAX);
  // quotient of a 10-bit index by at least 16 fits in 6 bits
  localparam int RED_STEPS = 6;

  // index modulo COLUMNS by restoring subtraction
  function automatic logic [INDEX_W-1:0] col_reduce(input logic [INDEX_W-1:0] v_in);
    logic [INDEX_W-1:0] v;
    v = v_in;
    for (int k = RED_STEPS - 1; k >= 0; k--) begin
      if (longint'(v) >= (longint'(COLUMNS) << k)) begin
        v = v - INDEX_W'(longint'(COLUMNS) << k);
      end
    end
    return v;
  endfunction

  logic [COL_W-1:0] col      [ROWS];
  logic [COL_W-1:0] clr_addr;
  logic [CNT_W-1:0] rdata    [ROWS];
  logic [CNT_W-1:0] least;
  logic [CNT_W-1:0] least_c;
  logic             qry;

  // clear pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + COL_W'(1);
    end
  end

  assign sts.clear_last = (clr_addr == COL_W'(COLUMNS - 1));

  // captured item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      qry <= opcode;
      for (int r = 0; r < ROWS; r++) begin
        col[r] <= COL_W'({{COL_W{1'b0}}, col_reduce(idx[r % INDEX_FIELDS])});
      end
    end
  end

  // counter banks
  for (genvar g = 0; g < ROWS; g++) begin : g_bank
    logic [CNT_W-1:0] mem [COLUMNS];
    logic             we;
    logic [COL_W-1:0] waddr;
    logic [CNT_W-1:0] wdata;

    assign we = cmd.clear ||
                (cmd.update && (qry == OP_INSERT) && (least != CNT_MAX) &&
                 (rdata[g] == least));
    assign waddr = cmd.clear ? clr_addr : col[g];
    assign wdata = cmd.clear ? '0 : least + CNT_W'(1);

    always_ff @(posedge clk) begin
      if (we) begin
        mem[waddr] <= wdata;
      end
      if (cmd.read) begin
        rdata[g] <= mem[col[g]];
      end
    end
  end

  // minimum over the rows
  always_comb begin
    least_c = CNT_MAX;
    for (int r = 0; r < ROWS; r++) begin
      if (rdata[r] < least_c) begin
        least_c = rdata[r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.min) begin
      least <= least_c;
    end
  end

  // query result
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      estimate <= EST_W'({{EST_W{1'b0}}, least});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.update && (qry == OP_QUERY);
    end
  end

endmodule

// File: design/cus_checker.sv
// ----------------------------------------------------------------------------
// cus_checker
// port-level checks on the sketch's command and result timing
// ----------------------------------------------------------------------------
module cus_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic opcode,
  input logic done
);
  import cus_pkg::*;

  // the clearing pass holds the block busy right after reset
  a_busy_after_rst: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low right after reset");

  // an accepted transfer makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy low after an accepted transfer");

  // results are single-cycle pulses
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

  // every result belongs to an accepted query
  a_done_query: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(start && !busy, 4) && ($past(opcode, 4) == OP_QUERY)))
    else $error("result without a matching query");

endmodule

bind conservative_update_sketch cus_checker u_cus_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .opcode (opcode),
  .done   (done)
);

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the conservative update sketch: a queue-fed driver
// sends insert and query commands, a shadow counter table predicts every
// estimate, and a monitor checks each done strobe against the oldest one
// ----------------------------------------------------------------------------
module tb;
  import cus_pkg::*;

  localparam int              ROWS         = CUS_ROWS;
  localparam int              COLUMNS      = CUS_COLUMNS;
  localparam longint unsigned COUNTER_MAX  = CUS_COUNTER_MAX;
  localparam int              RANDOM_ITEMS = 640;
  localparam int              POOL_KEYS    = 16;
  // back to back inserts on one key to build up a large count
  localparam int              SAT_INSERTS  = 32;
  // idle cycles tolerated with no transfer and no result; the clearing pass
  // after reset is the longest legal stretch
  localparam int              STALL_LIMIT  = 6000;
  // cycles after the last estimate, enough to catch a stray strobe
  localparam int              TAIL_CYCLES  = 12;

  // index fields, row0_index in the low slice
  typedef logic [INDEX_FIELDS-1:0][INDEX_W-1:0] index_set_t;

  typedef struct {
    logic        op;
    index_set_t  idx;
    int unsigned gap;    // idle cycles after the previous transfer
    bit          drain;  // hold back until every pending estimate has come
  } sketch_item_t;

  logic                 clk        = 1'b0;
  logic                 rst        = 1'b1;
  logic                 start      = 1'b0;
  logic                 opcode     = OP_INSERT;
  logic [INDEX_W-1:0]   row0_index = '0;
  logic [INDEX_W-1:0]   row1_index = '0;
  logic [INDEX_W-1:0]   row2_index = '0;
  logic [INDEX_W-1:0]   row3_index = '0;
  logic                 busy;
  logic [EST_W-1:0]     estimate;
  logic                 done;

  sketch_item_t         pending_items[$];
  logic [EST_W-1:0]     expected_estimates[$];
  sketch_item_t         cur_item;
  int unsigned          gap_count;
  int unsigned          stall_cycles;
  int unsigned          error_count;

  // shadow of every counter; zero matches the state after the clearing pass
  longint unsigned      shadow_counts [ROWS][COLUMNS];

  conservative_update_sketch #(
    .ROWS        (ROWS),
    .COLUMNS     (COLUMNS),
    .COUNTER_MAX (COUNTER_MAX)
  ) uut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .opcode     (opcode),
    .row0_index (row0_index),
    .row1_index (row1_index),
    .row2_index (row2_index),
    .row3_index (row3_index),
    .estimate   (estimate),
    .done       (done)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // conservative update on the shadow table; a query queues its estimate
  function automatic void sketch_apply(input sketch_item_t item);
    int unsigned     col [ROWS];
    longint unsigned cnt [ROWS];
    longint unsigned least;
    logic [EST_W-1:0] est;
    least = COUNTER_MAX;
    for (int r = 0; r < ROWS; r++) begin
      // rows beyond the index fields reuse them, columns wrap
      col[r] = int'(item.idx[r % INDEX_FIELDS]) % COLUMNS;
      cnt[r] = shadow_counts[r][col[r]];
      if (cnt[r] < least) least = cnt[r];
    end
    if (item.op == OP_QUERY) begin
      est = least[EST_W-1:0];
      expected_estimates.insert(expected_estimates.size(), est);
    end else if (least != COUNTER_MAX) begin
      // only the counters sitting at the minimum move up
      for (int r = 0; r < ROWS; r++)
        if (cnt[r] == least) shadow_counts[r][col[r]] = least + 1;
    end
  endfunction

  function automatic void add_item(input logic op, input index_set_t idx,
                                   input int unsigned gap, input bit drain);
    sketch_item_t it;
    it.op    = op;
    it.idx   = idx;
    it.gap   = gap;
    it.drain = drain;
    pending_items.insert(pending_items.size(), it);
  endfunction

  // driver: one transfer per edge at most; a following item with no gap
  // keeps start high across the edge instead of dropping it
  always @(posedge clk) begin
    bit taken;
    taken = start && !busy;
    if (rst) begin
      start      <= 1'b0;
      opcode     <= OP_INSERT;
      row0_index <= '0;
      row1_index <= '0;
      row2_index <= '0;
      row3_index <= '0;
      gap_count   = 0;
    end else begin
      if (taken) begin
        sketch_apply(cur_item);
        gap_count = 0;
      end
      if (taken || !start) begin
        if (pending_items.size() != 0 && gap_count >= pending_items[0].gap &&
            (!pending_items[0].drain || expected_estimates.size() == 0)) begin
          cur_item    = pending_items.pop_front();
          start      <= 1'b1;
          opcode     <= cur_item.op;
          row0_index <= cur_item.idx[0];
          row1_index <= cur_item.idx[1];
          row2_index <= cur_item.idx[2];
          row3_index <= cur_item.idx[3];
        end else begin
          start     <= 1'b0;
          gap_count  = gap_count + 1;
        end
      end
    end
  end

  // monitor: done lasts one cycle and cannot be held off
  always @(posedge clk) begin
    logic [EST_W-1:0] want;
    if (!rst && done) begin
      if (expected_estimates.size() == 0) begin
        $error("estimate: unexpected result, expected none, actual %0d", estimate);
        error_count++;
      end else begin
        want = expected_estimates.pop_front();
        if (estimate !== want) begin
          $error("estimate: expected %0d, actual %0d", want, estimate);
          error_count++;
        end
      end
    end
  end

  // watchdog: cycles with neither a transfer nor a result
  always @(posedge clk) begin
    if (rst || (start && !busy) || done)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    index_set_t  pool [POOL_KEYS];
    index_set_t  sat_key;
    index_set_t  key;
    int unsigned sel;
    int unsigned g;
    bit          burst;
    bit          dr;

    error_count = 0;
    sat_key     = {10'h30F, 10'h0F0, 10'h2AA, 10'h155};

    // directed: index extremes, insert then query with no gap, the
    // conservative rule on partly shared cells, alternating bit patterns
    add_item(OP_QUERY,  {10'd0, 10'd0, 10'd0, 10'd0},         $urandom_range(0, 10), 0);
    add_item(OP_QUERY,  {10'd1023, 10'd1023, 10'd1023, 10'd1023}, 0, 0);
    add_item(OP_INSERT, {10'd0, 10'd0, 10'd0, 10'd0},         $urandom_range(0, 10), 0);
    add_item(OP_QUERY,  {10'd0, 10'd0, 10'd0, 10'd0},         0, 0);
    add_item(OP_INSERT, {10'd1023, 10'd1023, 10'd1023, 10'd1023}, 0, 0);
    add_item(OP_INSERT, {10'd1023, 10'd1023, 10'd1023, 10'd1023}, 0, 0);
    add_item(OP_QUERY,  {10'd1023, 10'd1023, 10'd1023, 10'd1023}, 0, 0);
    // row 0 shares column 0 with the all-zero key, so only rows 1..3 move
    add_item(OP_INSERT, {10'd3, 10'd2, 10'd1, 10'd0},         $urandom_range(0, 10), 0);
    add_item(OP_QUERY,  {10'd3, 10'd2, 10'd1, 10'd0},         0, 0);
    add_item(OP_INSERT, {10'd3, 10'd2, 10'd1, 10'd0},         $urandom_range(0, 10), 0);
    add_item(OP_QUERY,  {10'd0, 10'd0, 10'd0, 10'd0},         $urandom_range(0, 10), 0);
    add_item(OP_INSERT, {10'd0, 10'd1023, 10'd0, 10'd1023},   $urandom_range(0, 10), 0);
    add_item(OP_QUERY,  {10'd0, 10'd1023, 10'd0, 10'd1023},   0, 0);
    add_item(OP_INSERT, {10'd1023, 10'd0, 10'd1023, 10'd0},   $urandom_range(0, 10), 0);
    add_item(OP_QUERY,  {10'd1023, 10'd0, 10'd1023, 10'd0},   $urandom_range(0, 10), 0);
    add_item(OP_INSERT, {10'h155, 10'h2AA, 10'h155, 10'h2AA}, 0, 0);
    add_item(OP_INSERT, {10'h2AA, 10'h155, 10'h2AA, 10'h155}, 0, 0);
    add_item(OP_QUERY,  {10'h155, 10'h2AA, 10'h155, 10'h2AA}, $urandom_range(0, 10), 1);
    add_item(OP_QUERY,  {10'h2AA, 10'h155, 10'h2AA, 10'h155}, 0, 0);
    add_item(OP_QUERY,  {10'd3, 10'd2, 10'd1, 10'd0},         0, 0);

    // hammer one key back to back, with an occasional query along the way
    for (int k = 0; k < SAT_INSERTS; k++) begin
      add_item(OP_INSERT, sat_key, 0, 0);
      if (k % 8 == 7) add_item(OP_QUERY, sat_key, 0, 0);
    end
    add_item(OP_QUERY, sat_key, $urandom_range(0, 10), 0);
    // half shared key: the fresh rows move, the heavily counted ones stay put
    key = {10'h00F, 10'h3F0, sat_key[1], sat_key[0]};
    add_item(OP_INSERT, key, 0, 0);
    add_item(OP_QUERY,  key, 0, 0);
    add_item(OP_QUERY,  sat_key, 0, 1);

    // small key pool so counts build up; narrow index draws force
    // collisions between keys on single rows
    pool[0] = sat_key;
    for (int p = 1; p < POOL_KEYS; p++)
      for (int r = 0; r < INDEX_FIELDS; r++)
        pool[p][r] = ($urandom_range(0, 3) == 0) ? INDEX_W'($urandom_range(0, 7))
                                                 : INDEX_W'($urandom_range(0, 1023));

    burst = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // stretches of 50 items either idle at random or not at all
      if (n % 50 == 0) burst = ($urandom_range(0, 3) == 0);
      g  = burst ? 0 : $urandom_range(0, 10);
      dr = (n == 0) || ($urandom_range(0, 49) == 0);
      sel = $urandom_range(0, 99);
      if (sel < 60) begin
        key = pool[$urandom_range(0, POOL_KEYS - 1)];
      end else if (sel < 70) begin
        // a pool key with one row swapped for a random column
        key = pool[$urandom_range(0, POOL_KEYS - 1)];
        key[$urandom_range(0, INDEX_FIELDS - 1)] = INDEX_W'($urandom_range(0, 1023));
      end else begin
        for (int r = 0; r < INDEX_FIELDS; r++)
          key[r] = INDEX_W'($urandom_range(0, 1023));
      end
      add_item($urandom_range(0, 1) ? OP_QUERY : OP_INSERT, key, g, dr);
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // every transfer made, then every estimate back, then a quiet tail
    while (pending_items.size() != 0 || start) @(posedge clk);
    while (expected_estimates.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
